// ===== hw/rtl/ssl_pkg.sv =====
// Shared types and constants for the synchronized slew limiter.
// Holds payload structs, command and status structs, and the state and op codes.
// Depends on nothing.
package ssl_pkg;

  localparam int AxisW    = 16;
  localparam int PeriodW  = 12;
  localparam int CapW     = 15;
  localparam int DivW     = AxisW + 1;
  localparam int DsrW     = (CapW > DivW) ? CapW : DivW;
  localparam int CntW     = $clog2(DivW);
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  typedef struct packed {
    logic signed [AxisW-1:0] target_x;
    logic signed [AxisW-1:0] target_y;
    logic signed [AxisW-1:0] target_turn;
    logic [PeriodW-1:0]      target_period;
  } in_t;

  typedef struct packed {
    logic signed [AxisW-1:0] out_x;
    logic signed [AxisW-1:0] out_y;
    logic signed [AxisW-1:0] out_turn;
    logic [PeriodW-1:0]      out_period;
  } out_t;

  typedef struct packed {
    logic [CapW-1:0]    x_cap;
    logic [CapW-1:0]    y_cap;
    logic [CapW-1:0]    turn_cap;
    logic [PeriodW-1:0] period_cap;
  } caps_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_CAP      = 4'd0,
    REG_Y_CAP      = 4'd1,
    REG_TURN_CAP   = 4'd2,
    REG_PERIOD_CAP = 4'd3
  } reg_e;

  // Six divisions per item: three latch counts, then three per-axis strides.
  typedef enum logic [2:0] {
    OP_CNT_X  = 3'd0,
    OP_CNT_Y  = 3'd1,
    OP_CNT_T  = 3'd2,
    OP_STEP_X = 3'd3,
    OP_STEP_Y = 3'd4,
    OP_STEP_T = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_STORE,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic div_store;
    logic commit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/ssl_ctrl.sv =====
// Sequencer for the slew limiter: accepts a target, runs six serial divisions.
// Depends on ssl_pkg.
module ssl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssl_pkg::sts_t sts_i,
  output ssl_pkg::cmd_t cmd_o
);
  import ssl_pkg::*;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_CNT_X;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.op       = op_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = OP_CNT_X;
          state_d       = sts_i.first ? S_COMMIT : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_RUN;
      end
      S_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.div_store = 1'b1;
        state_d         = S_LOAD;
        unique case (op_q)
          OP_CNT_X:  op_d = OP_CNT_Y;
          OP_CNT_Y:  op_d = OP_CNT_T;
          OP_CNT_T:  op_d = OP_STEP_X;
          OP_STEP_X: op_d = OP_STEP_Y;
          OP_STEP_Y: op_d = OP_STEP_T;
          default: begin
            op_d    = OP_CNT_X;
            state_d = S_COMMIT;
          end
        endcase
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ssl_datapath.sv =====
// Datapath of the slew limiter: position state, shared serial divider, output register.
// Depends on ssl_pkg.
module ssl_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssl_pkg::caps_t caps_i,
  input  ssl_pkg::in_t   in_data_i,
  input  ssl_pkg::cmd_t  cmd_i,
  output ssl_pkg::sts_t  sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssl_pkg::out_t  out_data_o
);
  import ssl_pkg::*;

  in_t                     tgt_q;
  logic signed [AxisW-1:0] pos_q [3];
  logic [PeriodW-1:0]      pos_p_q;
  logic                    have_q;
  logic [DivW-1:0]         mag_q  [3];
  logic                    neg_q  [3];
  logic [DivW-1:0]         step_q [3];
  logic [DivW-1:0]         n_q;
  logic [DsrW-1:0]         rem_q;
  logic [DivW-1:0]         quo_q;
  logic [DsrW-1:0]         dsr_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic signed [AxisW-1:0] tgt_ax [3];
  logic [1:0]              axis;
  logic                    is_cnt;
  logic [CapW-1:0]         cap_sel;

  assign tgt_ax[0] = in_data_i.target_x;
  assign tgt_ax[1] = in_data_i.target_y;
  assign tgt_ax[2] = in_data_i.target_turn;

  always_comb begin
    unique case (cmd_i.op)
      OP_CNT_X:  begin axis = 2'd0; is_cnt = 1'b1; end
      OP_CNT_Y:  begin axis = 2'd1; is_cnt = 1'b1; end
      OP_CNT_T:  begin axis = 2'd2; is_cnt = 1'b1; end
      OP_STEP_X: begin axis = 2'd0; is_cnt = 1'b0; end
      OP_STEP_Y: begin axis = 2'd1; is_cnt = 1'b0; end
      default:   begin axis = 2'd2; is_cnt = 1'b0; end
    endcase
    unique case (axis)
      2'd0:    cap_sel = caps_i.x_cap;
      2'd1:    cap_sel = caps_i.y_cap;
      default: cap_sel = caps_i.turn_cap;
    endcase
  end

  // Restoring division, one quotient bit per step.
  logic [DsrW:0]   trial;
  logic            ge;
  logic [DsrW:0]   diff;
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // Latch count from the finished count division; a zero cap or zero delta counts as one.
  logic [DivW-1:0] cnt_val;
  always_comb begin
    if (dsr_q == '0) begin
      cnt_val = DivW'(1);
    end else begin
      cnt_val = quo_q + DivW'(rem_q != '0);
      if (cnt_val == '0) begin
        cnt_val = DivW'(1);
      end
    end
  end

  // Commit values.
  logic signed [DivW-1:0]    sstep [3];
  logic signed [DivW-1:0]    psum  [3];
  logic signed [AxisW-1:0]   pos_d [3];
  logic signed [PeriodW+1:0] dp;
  logic signed [PeriodW+1:0] pc;
  logic signed [PeriodW+1:0] psum_p;
  logic [PeriodW-1:0]        pos_p_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sstep[i] = neg_q[i] ? -$signed(step_q[i]) : $signed(step_q[i]);
      psum[i]  = DivW'(pos_q[i]) + sstep[i];
      pos_d[i] = have_q ? psum[i][AxisW-1:0] : tgt_q[i == 0 ? 3*AxisW+PeriodW-1 :
                 (i == 1 ? 2*AxisW+PeriodW-1 : AxisW+PeriodW-1) -: AxisW];
    end
    dp = $signed({2'b00, tgt_q.target_period}) - $signed({2'b00, pos_p_q});
    pc = $signed({2'b00, caps_i.period_cap});
    if (dp > pc) begin
      dp = pc;
    end
    if (dp < -pc) begin
      dp = -pc;
    end
    psum_p  = $signed({2'b00, pos_p_q}) + dp;
    pos_p_d = have_q ? psum_p[PeriodW-1:0] : tgt_q.target_period;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      pos_p_q  <= '0;
    end else if (cmd_i.commit) begin
      have_q   <= 1'b1;
      pos_q[0] <= pos_d[0];
      pos_q[1] <= pos_d[1];
      pos_q[2] <= pos_d[2];
      pos_p_q  <= pos_p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        logic signed [DivW-1:0] d;
        d         = DivW'(tgt_ax[i]) - DivW'(pos_q[i]);
        neg_q[i]  <= d[DivW-1];
        mag_q[i]  <= d[DivW-1] ? DivW'(-d) : DivW'(d);
      end
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= mag_q[axis];
      dsr_q <= is_cnt ? DsrW'(cap_sel) : DsrW'(n_q);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
    if (cmd_i.div_store) begin
      if (is_cnt) begin
        if (cmd_i.op == OP_CNT_X || cnt_val > n_q) begin
          n_q <= cnt_val;
        end
      end else begin
        step_q[axis] <= quo_q;
      end
    end
  end

  // Output register: hold the result until taken, refill on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.out_x      <= pos_d[0];
      out_q.out_y      <= pos_d[1];
      out_q.out_turn   <= pos_d[2];
      out_q.out_period <= pos_p_d;
    end
  end

  assign sts_o.first    = !have_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== hw/rtl/synchronized_slew_limiter.sv =====
// Top level of the synchronized slew limiter: configuration registers and the
// controller and datapath. Depends on ssl_pkg, ssl_ctrl and ssl_datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | in_data_i   (ssl_pkg::in_t)
//   out     | out       | out_valid_o/out_ready_i | out_data_o  (ssl_pkg::out_t)
//
// Sequence: the first target after reset goes straight from accept to commit. Every
// later target runs six divisions through one shared restoring divider, each
// a load, 17 bit steps and a store, between accept and commit. The divider
// resolves one quotient bit per cycle.
// Reset: caps return to 500/300/300/20 and no position is latched.
// Stalls: a finished transaction waits in the output register while the next
// target is taken; commit only stalls if that register is still full.
module synchronized_slew_limiter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ssl_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ssl_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssl_pkg::out_t                   out_data_o
);
  import ssl_pkg::*;

  caps_t caps_q;
  cmd_t  cmd;
  sts_t  sts;

  // Writes are always taken; only the register's own bits are kept and
  // indexes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q.x_cap      <= CapW'(500);
      caps_q.y_cap      <= CapW'(300);
      caps_q.turn_cap   <= CapW'(300);
      caps_q.period_cap <= PeriodW'(20);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_CAP:      caps_q.x_cap      <= cfg_data_i[CapW-1:0];
        REG_Y_CAP:      caps_q.y_cap      <= cfg_data_i[CapW-1:0];
        REG_TURN_CAP:   caps_q.turn_cap   <= cfg_data_i[CapW-1:0];
        REG_PERIOD_CAP: caps_q.period_cap <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Sequence the accept, the six divisions and the commit.
  ssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold position state, run the divider and present the result.
  ssl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .caps_i      (caps_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for synchronized_slew_limiter: directed and random targets are
// slewed by an in-bench model and every result is compared field by field.
// Depends on ssl_pkg and the synchronized_slew_limiter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssl_pkg::*;

  // Indexes past the register list: writes there must leave every cap alone.
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = CfgIdxW'(REG_PERIOD_CAP) + 1'b1;
  localparam logic [CfgIdxW-1:0] LastIdx        = '1;

  localparam int AxisMax   = 32767;
  localparam int AxisMin   = -32768;
  localparam int PeriodMax = 4095;
  localparam int CapMax    = 32767;

  // Settle time after the last result: one full six-division item plus margin.
  localparam int TailCycles = 120;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic  [CfgIdxW-1:0]  cfg_index_i = '0;
  logic  [CfgDataW-1:0] cfg_data_i  = '0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  synchronized_slew_limiter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Slew model: caps as the block holds them, and the latched command.
  // Both start at their reset values; reset is applied once only.
  // ---------------------------------------------------------------------------
  int cap_x      = 500;
  int cap_y      = 300;
  int cap_turn   = 300;
  int cap_period = 20;

  bit have_latch = 1'b0;
  int lat_x      = 0;
  int lat_y      = 0;
  int lat_turn   = 0;
  int lat_period = 0;

  out_t slewed_q[$];      // slewed commands still owed by the block, oldest first
  int   mismatches     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  // Latches an axis needs to cover delta at cap per latch; a zero cap means one.
  function automatic int latch_count(input int delta, input int cap);
    int mag;
    if (cap == 0) return 1;
    mag = (delta < 0) ? -delta : delta;
    latch_count = (mag + cap - 1) / cap;
    if (latch_count < 1) latch_count = 1;
  endfunction

  // Advance the latched command one latch towards t and return what the block applies.
  function automatic out_t slew_toward(input in_t t);
    int   tx, ty, tt, tp;
    int   dx, dy, dt, dp;
    int   n, ny, nt;
    out_t r;
    tx = $signed(t.target_x);
    ty = $signed(t.target_y);
    tt = $signed(t.target_turn);
    tp = t.target_period;
    if (!have_latch) begin
      // First target after reset: take it whole.
      lat_x      = tx;
      lat_y      = ty;
      lat_turn   = tt;
      lat_period = tp;
      have_latch = 1'b1;
    end else begin
      dx = tx - lat_x;
      dy = ty - lat_y;
      dt = tt - lat_turn;
      n  = latch_count(dx, cap_x);
      ny = latch_count(dy, cap_y);
      nt = latch_count(dt, cap_turn);
      if (ny > n) n = ny;
      if (nt > n) n = nt;
      if (n <= 1) begin
        lat_x    = tx;
        lat_y    = ty;
        lat_turn = tt;
      end else begin
        // Equal share of the slowest axis' latch count: all three arrive together.
        // SystemVerilog integer division truncates towards zero.
        lat_x    += dx / n;
        lat_y    += dy / n;
        lat_turn += dt / n;
      end
      // Period runs on its own symmetric clamp.
      dp = tp - lat_period;
      if (dp > cap_period)  dp = cap_period;
      if (dp < -cap_period) dp = -cap_period;
      lat_period += dp;
    end
    r.out_x      = AxisW'(lat_x);
    r.out_y      = AxisW'(lat_y);
    r.out_turn   = AxisW'(lat_turn);
    r.out_period = PeriodW'(lat_period);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random and check every transaction against the oldest
  // slewed command. Outputs are sampled at the edge, before the block updates.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (slewed_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", $signed(got.out_x), 0);
      return;
    end
    want = slewed_q.pop_front();
    if (got.out_x !== want.out_x)
      report_mismatch("out_x", $signed(got.out_x), $signed(want.out_x));
    if (got.out_y !== want.out_y)
      report_mismatch("out_y", $signed(got.out_y), $signed(want.out_y));
    if (got.out_turn !== want.out_turn)
      report_mismatch("out_turn", $signed(got.out_turn), $signed(want.out_turn));
    if (got.out_period !== want.out_period)
      report_mismatch("out_period", got.out_period, want.out_period);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task returns right after a rising edge.
  // ---------------------------------------------------------------------------

  // Send one target. Valid is only dropped inside an idle gap, so a back-to-back
  // target keeps valid high without a second assignment in the same step.
  task automatic send_target(input in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    slewed_q.push_back(slew_toward(t));
  endtask

  // Hold the input off until every outstanding command has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (slewed_q.size() != 0);
  endtask

  // Write one register; only the register's own bits are kept.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_X_CAP:      cap_x      = val[CapW-1:0];
      REG_Y_CAP:      cap_y      = val[CapW-1:0];
      REG_TURN_CAP:   cap_turn   = val[CapW-1:0];
      REG_PERIOD_CAP: cap_period = val[PeriodW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_caps(input int xc, input int yc, input int tc, input int pc);
    write_reg(REG_X_CAP,      CfgDataW'(xc));
    write_reg(REG_Y_CAP,      CfgDataW'(yc));
    write_reg(REG_TURN_CAP,   CfgDataW'(tc));
    write_reg(REG_PERIOD_CAP, CfgDataW'(pc));
  endtask

  // Random cap with stray high bits: zero, all ones, anything, or a small stride.
  function automatic logic [CfgDataW-1:0] pick_cap(input logic [CfgDataW-1:0] junk_mask);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1, 1500)) | (CfgDataW'($urandom) & junk_mask);
    endcase
  endfunction

  task automatic randomise_caps();
    write_reg(REG_X_CAP,      pick_cap(16'h8000));
    write_reg(REG_Y_CAP,      pick_cap(16'h8000));
    write_reg(REG_TURN_CAP,   pick_cap(16'h8000));
    write_reg(REG_PERIOD_CAP, pick_cap(16'hF000));
    // Now and then poke an unused index with junk.
    if ($urandom_range(1))
      write_reg(CfgIdxW'($urandom_range(FirstUnusedIdx, LastIdx)), CfgDataW'($urandom));
  endtask

  function automatic in_t make_target(input int x, input int y, input int tn, input int p);
    in_t t;
    t.target_x      = AxisW'(x);
    t.target_y      = AxisW'(y);
    t.target_turn   = AxisW'(tn);
    t.target_period = PeriodW'(p);
    return t;
  endfunction

  // Axis goal: mostly a few latches away from where the axis sits, so goals are
  // reached; otherwise full range or a rail.
  function automatic int pick_axis(input int here, input int cap);
    int v, span;
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? AxisMax : AxisMin;
      1, 2, 3: v = $signed(AxisW'($urandom));
      default: begin
        span = ((cap == 0) ? 64 : cap) * int'($urandom_range(1, 5));
        v    = here + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    if (v > AxisMax) v = AxisMax;
    if (v < AxisMin) v = AxisMin;
    return v;
  endfunction

  function automatic int pick_period(input int here, input int cap);
    int v, span;
    case ($urandom_range(5))
      0:       v = $urandom_range(1) ? PeriodMax : 0;
      1, 2:    v = $urandom_range(0, PeriodMax);
      default: begin
        span = ((cap == 0) ? 16 : cap) * int'($urandom_range(1, 5));
        v    = here + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    if (v > PeriodMax) v = PeriodMax;
    if (v < 0)         v = 0;
    return v;
  endfunction

  // Mostly hold a goal over a run of latches so the axes converge on it; the rest
  // is lone items with every bit random.
  task automatic run_random(input int items);
    in_t         goal;
    logic [63:0] bits;
    int          left;
    for (int half = 0; half < 2; half++) begin
      if (half == 1) begin
        drain();
        randomise_caps();
      end
      left = items / 2;
      while (left > 0) begin
        if ($urandom_range(4) == 0) begin
          bits = {$urandom, $urandom};
          send_target(bits[$bits(in_t)-1:0]);
          left--;
        end else begin
          goal = make_target(pick_axis(lat_x, cap_x), pick_axis(lat_y, cap_y),
                             pick_axis(lat_turn, cap_turn),
                             pick_period(lat_period, cap_period));
          repeat ($urandom_range(2, 12)) begin
            send_target(goal);
            left--;
          end
        end
        // Let the pipeline run dry once in a while before carrying on.
        if ($urandom_range(199) == 0) drain();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First target is latched whole; then rail-to-rail swings under the reset caps,
  // with each swing target sent twice in a row.
  task automatic test_first_latch();
    send_target(make_target(AxisMin, AxisMax, AxisMin, PeriodMax));
    send_target(make_target(AxisMax, AxisMin, AxisMax, 0));
    send_target(make_target(AxisMax, AxisMin, AxisMax, 0));
    send_target(make_target(0, 0, 0, 2048));
    send_target(make_target(0, 0, 0, 2048));
  endtask

  // Zero caps: the axis drops out of the latch count; a zero period cap freezes it.
  task automatic test_zero_caps();
    drain();
    write_reg(REG_X_CAP, '0);
    send_target(make_target(1000, -1000, 500, 100));
    drain();
    set_caps(0, 0, 0, 0);
    send_target(make_target(AxisMin, AxisMax, AxisMin, PeriodMax));
    send_target(make_target(AxisMax, AxisMin, AxisMax, 0));
    drain();
    set_caps(1, 1, 1, 1);
    send_target(make_target(5, -3, 0, PeriodMax));
    send_target(make_target(AxisMin, AxisMax, 1, 0));
  endtask

  // Stray high bits are dropped and unused indexes change nothing.
  task automatic test_register_width();
    drain();
    set_caps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(FirstUnusedIdx, '0);
    write_reg(LastIdx, '0);
    send_target(make_target(AxisMin, AxisMin, AxisMin, 0));
    send_target(make_target(AxisMax, AxisMax, AxisMax, PeriodMax));
    send_target(make_target(AxisMin, AxisMax, 0, 0));
    drain();
    write_reg(REG_X_CAP, 16'h8000);
    write_reg(REG_PERIOD_CAP, 16'hF000);
    send_target(make_target(AxisMax, AxisMin, AxisMax, PeriodMax));
    send_target(make_target(-1, 1, -1, 1));
  endtask

  task automatic test_no_idling();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_caps(500, 300, 300, 20);
    run_random(440);
  endtask

  task automatic test_sender_idle();
    drain();
    send_idle_pct  = 61;
    recv_stall_pct = 0;
    set_caps(1, 1, 1, 1);
    run_random(440);
  endtask

  task automatic test_receiver_stall();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    set_caps(CapMax, CapMax, CapMax, PeriodMax);
    run_random(440);
  endtask

  task automatic test_both_idle();
    drain();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    randomise_caps();
    run_random(440);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, let the block settle, judge.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_latch();
    test_zero_caps();
    test_register_width();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && slewed_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs a few milliseconds at most.
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_ctrl.sv
hw/rtl/ssl_datapath.sv
hw/rtl/synchronized_slew_limiter.sv
tb/tb_top.sv
